FILE: hdl/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

   // item command codes
   typedef enum logic [0:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // control sequencer
   typedef enum logic [0:0] {
      S_IDLE = 1'b0,
      S_POP  = 1'b1
   } state_type;

   localparam int BLOCK_W  = 5;
   localparam int STATUS_W = 2;
   localparam int FREE_W   = 6;

endpackage

`default_nettype wire

FILE: hdl/fbpa_ram.sv
`default_nettype none

module fbpa_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hdl/fixed_block_pool_allocator_top.sv
// the result of every item shows on rsp_* in the cycle after it is accepted
// a free never sets busy; an allocate that leaves free blocks behind sets busy
//    in S_POP while the link memory returns the next head
// other allocates (pool empty, or the last block handed out) never set busy either
// reset: synchronous, active high; head 0, count NUM_BLOCKS, no link entries set up
// the link memory is not cleared; entries are set up lazily by allocates
`default_nettype none

module fixed_block_pool_allocator_top #(
   parameter int NUM_BLOCKS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_command,
   input  wire logic [fbpa_pkg::BLOCK_W-1:0]    req_free_block,
   output logic                                 rsp_valid,
   output logic      [fbpa_pkg::BLOCK_W-1:0]    rsp_granted_block,
   output logic      [fbpa_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [fbpa_pkg::FREE_W-1:0]     rsp_blocks_free
);

   import fbpa_pkg::*;

   // head, links and counts must hold the sentinel value NUM_BLOCKS
   localparam int HEAD_W = $clog2(NUM_BLOCKS + 1);
   localparam int ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam logic [HEAD_W-1:0] NB = HEAD_W'(NUM_BLOCKS);

   // control state
   state_type         state_ff, state_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [HEAD_W-1:0] count_ff, count_in;
   logic [HEAD_W-1:0] init_ff, init_in;

   // forwarding of the lazy-init write into the pending head read
   logic              fwd_ff, fwd_in;
   logic [HEAD_W-1:0] fwd_data_ff, fwd_data_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]  rsp_granted_ff, rsp_granted_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [FREE_W-1:0]   rsp_free_ff, rsp_free_in;

   // link memory port signals
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [HEAD_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [HEAD_W-1:0] ram_rd_data;

   // decode of the incoming item
   logic              accept;
   logic              is_alloc;
   logic              init_en;
   logic              pool_ok;
   logic              free_ok;
   logic              pop_link;
   logic [HEAD_W-1:0] init_next;
   logic [HEAD_W-1:0] count_dec;

   fbpa_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (NUM_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      accept    = start && !busy;
      is_alloc  = (req_command == CMD_ALLOC);
      // one more link entry is set up on every allocate until all exist
      init_en   = accept && is_alloc && (init_ff < NB);
      init_next = HEAD_W'(init_ff + 1'b1);
      count_dec = HEAD_W'(count_ff - 1'b1);
      // a corrupted head (only after double frees) reads as an empty pool
      pool_ok   = (count_ff != '0) && (head_ff < NB);
      free_ok   = (count_ff < NB) && ({27'd0, req_free_block} < 32'(NUM_BLOCKS));
      // the popped block's link becomes the head unless the pool just ran dry
      pop_link  = accept && is_alloc && pool_ok && (count_dec != '0);
   end

   // link memory: lazy-init write on allocate, push write on free,
   // head link always read so it is ready the cycle after an allocate
   always_comb begin
      ram_wr_en   = init_en || (accept && !is_alloc && free_ok);
      ram_wr_addr = is_alloc ? ADDR_W'(init_ff) : ADDR_W'(req_free_block);
      ram_wr_data = is_alloc ? init_next : head_ff;
      ram_rd_addr = ADDR_W'(head_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop_link) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      unique case (state_ff)
         S_IDLE:  busy = 1'b0;
         S_POP:   busy = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   // datapath and result
   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      init_in        = init_ff;
      fwd_in         = fwd_ff;
      fwd_data_in    = fwd_data_ff;
      rsp_valid_in   = accept;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_free_in    = rsp_free_ff;

      if (state_ff == S_POP) begin
         // the link read of the old head returns now; take the forwarded
         // init value when the same entry was set up in the accept cycle
         head_in = fwd_ff ? fwd_data_ff : ram_rd_data;
      end

      if (accept) begin
         if (init_en) begin
            init_in = init_next;
         end
         fwd_in      = init_en && (init_ff == head_ff);
         fwd_data_in = init_next;

         if (is_alloc) begin
            if (pool_ok) begin
               rsp_granted_in = BLOCK_W'(head_ff);
               rsp_status_in  = ST_OK;
               count_in       = count_dec;
               if (count_dec == '0) begin
                  head_in = NB;
               end
            end else begin
               rsp_granted_in = '0;
               rsp_status_in  = ST_EMPTY;
            end
         end else begin
            rsp_granted_in = '0;
            if (free_ok) begin
               rsp_status_in = ST_OK;
               head_in       = HEAD_W'(req_free_block);
               count_in      = HEAD_W'(count_ff + 1'b1);
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         rsp_free_in = FREE_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= NB;
         init_ff      <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         init_ff      <= init_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      fwd_data_ff    <= fwd_data_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_free_ff    <= rsp_free_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_block = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_blocks_free   = rsp_free_ff;

endmodule

`default_nettype wire

FILE: hdl/fbpa_chk.sv
`default_nettype none

module fbpa_chk #(
   parameter int NUM_BLOCKS = 32
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          req_command,
   input wire logic                          rsp_valid,
   input wire logic [fbpa_pkg::BLOCK_W-1:0]  rsp_granted_block,
   input wire logic [fbpa_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [fbpa_pkg::FREE_W-1:0]   rsp_blocks_free
);

   import fbpa_pkg::*;

   // every accepted item gives its result in the next cycle
   a_item_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !reset) |=> rsp_valid)
      else $error("no result one cycle after an accepted item");

   // no result without an item accepted the cycle before
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result without an accepted item");

   // a failed allocate hands out block zero
   a_empty_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_granted_block == '0))
      else $error("empty pool result with nonzero block");

   // a full status only answers a free
   a_status_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> $past(req_command == CMD_FREE))
      else $error("ignored-free status on an allocate");

   // the free count never passes the pool size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({26'd0, rsp_blocks_free} <= 32'(NUM_BLOCKS)))
      else $error("free count above pool size");

endmodule

bind fixed_block_pool_allocator_top fbpa_chk #(
   .NUM_BLOCKS (NUM_BLOCKS)
) u_fbpa_chk (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_command       (req_command),
   .rsp_valid         (rsp_valid),
   .rsp_granted_block (rsp_granted_block),
   .rsp_status        (rsp_status),
   .rsp_blocks_free   (rsp_blocks_free)
);

`default_nettype wire
